>>> design/pbaw_pkg.sv
package pbaw_pkg;

  // Fixed widths of the gain registers and of the controller state
  localparam int GAIN_W    = 24;
  localparam int INTEG_W   = 48;
  localparam int SDIFF_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Shared multiplier: signed gain times a signed operand of up to 33 bits
  localparam int MUL_B_W  = 33;
  localparam int PROD_W   = GAIN_W + MUL_B_W;
  // Upper integrator half is weighted by 2^24
  localparam int HI_SHIFT = 24;
  // Accumulator, wide enough for gain_i * integrator with margin
  localparam int ACC_W    = 76;

  localparam int STEP_W = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P        = 2'd0,
    REG_GAIN_I        = 2'd1,
    REG_GAIN_D        = 2'd2,
    REG_GAIN_BACKCALC = 2'd3
  } cfg_reg_t;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RESET        = 24'sd4653;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RESET        = 24'sd5066;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RESET        = -24'sd206602;
  localparam logic signed [GAIN_W-1:0] GAIN_BACKCALC_RESET = 24'sd1026222;

  // Step hold condition
  typedef enum logic [1:0] {
    WAIT_NONE = 2'd0,
    WAIT_IN   = 2'd1,
    WAIT_OUT  = 2'd2
  } wait_t;

  // Multiplier operand selects
  typedef enum logic [1:0] {
    A_KB = 2'd0,
    A_GI = 2'd1,
    A_GP = 2'd2,
    A_GD = 2'd3
  } a_sel_t;

  typedef enum logic [2:0] {
    B_SD = 3'd0,
    B_LO = 3'd1,
    B_HI = 3'd2,
    B_E  = 3'd3,
    B_DE = 3'd4
  } b_sel_t;

  // Accumulator operations
  typedef enum logic [2:0] {
    ACC_NOP   = 3'd0,
    ACC_LOAD  = 3'd1,
    ACC_ADD   = 3'd2,
    ACC_SET   = 3'd3,
    ACC_SHIFT = 3'd4
  } acc_op_t;

  // One control word
  typedef struct packed {
    wait_t   waitc;
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    logic    prod_hi;
    acc_op_t acc_op;
    logic    integ_wr;
    logic    finish;
    logic    last;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    ucode_t uw;
    logic   go;
  } seq_ctrl_t;

  // Microprogram for one control tick
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    case (step)
      4'd0: begin
        // take sample, acc = integrator + error << F
        w.waitc  = WAIT_IN;
        w.acc_op = ACC_LOAD;
      end
      4'd1: begin
        w.a_sel  = A_KB;
        w.b_sel  = B_SD;
        w.acc_op = ACC_ADD;
      end
      4'd2: begin
        w.integ_wr = 1'b1;
      end
      4'd3: begin
        w.a_sel  = A_GI;
        w.b_sel  = B_LO;
        w.acc_op = ACC_SET;
      end
      4'd4: begin
        w.a_sel   = A_GI;
        w.b_sel   = B_HI;
        w.prod_hi = 1'b1;
        w.acc_op  = ACC_ADD;
      end
      4'd5: begin
        w.acc_op = ACC_SHIFT;
      end
      4'd6: begin
        w.a_sel  = A_GP;
        w.b_sel  = B_E;
        w.acc_op = ACC_ADD;
      end
      4'd7: begin
        w.a_sel  = A_GD;
        w.b_sel  = B_DE;
        w.acc_op = ACC_ADD;
      end
      4'd8: begin
        // clamp, publish result, update state
        w.waitc  = WAIT_OUT;
        w.finish = 1'b1;
        w.last   = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

>>> design/pbaw_sequencer.sv
module pbaw_sequencer
  import pbaw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_free,
  output seq_ctrl_t ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            uw;
  logic              go;

  // Control word lookup
  assign uw = ucode_rom(step);

  // A step holds until its wait condition is met
  always_comb begin
    case (uw.waitc)
      WAIT_IN:  go = in_valid;
      WAIT_OUT: go = out_free;
      default:  go = 1'b1;
    endcase
  end

  always_comb begin
    step_next = step;
    if (go) begin
      step_next = uw.last ? '0 : step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

  assign ctrl.uw = uw;
  assign ctrl.go = go;

endmodule

>>> design/pbaw_datapath.sv
module pbaw_datapath
  import pbaw_pkg::*;
#(
  parameter int SAMPLE_BITS        = 12,
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  seq_ctrl_t              ctrl,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [GAIN_W-1:0]      cfg_data,
  input  logic [SAMPLE_BITS-1:0] reference,
  input  logic [SAMPLE_BITS-1:0] measured,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   out_free,
  output logic [SAMPLE_BITS-1:0] drive,
  output logic [SAMPLE_BITS:0]   error_value,
  output logic                   saturated
);

  localparam int ERR_W = SAMPLE_BITS + 1;
  localparam int DE_W  = SAMPLE_BITS + 2;

  logic signed [GAIN_W-1:0]  gain_p;
  logic signed [GAIN_W-1:0]  gain_i;
  logic signed [GAIN_W-1:0]  gain_d;
  logic signed [GAIN_W-1:0]  gain_backcalc;

  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   prev_err;
  logic signed [DE_W-1:0]    err_diff;
  logic signed [INTEG_W-1:0] integ;
  logic signed [SDIFF_W-1:0] sdiff;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_next;

  logic signed [ERR_W-1:0]   err_in;
  logic signed [DE_W-1:0]    err_diff_in;
  logic signed [GAIN_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_ext;

  logic                      integ_pos;
  logic                      integ_neg;
  logic signed [INTEG_W-1:0] integ_sat;

  logic signed [ACC_W-1:0]   u;
  logic signed [ACC_W-1:0]   top;
  logic signed [ACC_W-1:0]   drive_wide;
  logic                      sat_now;
  logic signed [ACC_W:0]     diff;
  logic                      diff_pos;
  logic                      diff_neg;
  logic signed [SDIFF_W-1:0] sdiff_sat;

  logic                      step_go;

  assign step_go = ctrl.go;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= GAIN_P_RESET;
      gain_i        <= GAIN_I_RESET;
      gain_d        <= GAIN_D_RESET;
      gain_backcalc <= GAIN_BACKCALC_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN_P:        gain_p        <= cfg_data;
        REG_GAIN_I:        gain_i        <= cfg_data;
        REG_GAIN_D:        gain_d        <= cfg_data;
        REG_GAIN_BACKCALC: gain_backcalc <= cfg_data;
        default: ;
      endcase
    end
  end

  // Error and its difference from last tick
  assign err_in      = $signed({1'b0, reference}) - $signed({1'b0, measured});
  assign err_diff_in = DE_W'(err_in) - DE_W'(prev_err);

  // Shared multiplier operands
  always_comb begin
    case (ctrl.uw.a_sel)
      A_KB:    mul_a = gain_backcalc;
      A_GI:    mul_a = gain_i;
      A_GP:    mul_a = gain_p;
      A_GD:    mul_a = gain_d;
      default: mul_a = gain_p;
    endcase
  end

  always_comb begin
    case (ctrl.uw.b_sel)
      B_SD:    mul_b = MUL_B_W'(sdiff);
      B_LO:    mul_b = $signed({{(MUL_B_W-HI_SHIFT){1'b0}}, integ[HI_SHIFT-1:0]});
      B_HI:    mul_b = MUL_B_W'($signed(integ[INTEG_W-1:HI_SHIFT]));
      B_E:     mul_b = MUL_B_W'(err);
      B_DE:    mul_b = MUL_B_W'(err_diff);
      default: mul_b = '0;
    endcase
  end

  assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_ext = ctrl.uw.prod_hi ? (ACC_W'(prod) <<< HI_SHIFT) : ACC_W'(prod);

  // Accumulator
  always_comb begin
    acc_next = acc;
    case (ctrl.uw.acc_op)
      ACC_LOAD:  acc_next = ACC_W'(integ) + (ACC_W'(err_in) <<< GAIN_FRACTION_BITS);
      ACC_ADD:   acc_next = acc + prod_ext;
      ACC_SET:   acc_next = prod_ext;
      ACC_SHIFT: acc_next = acc >>> GAIN_FRACTION_BITS;
      default:   acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      acc <= acc_next;
    end
  end

  // Latch the tick's error terms
  always_ff @(posedge clk) begin
    if (step_go && ctrl.uw.acc_op == ACC_LOAD) begin
      err      <= err_in;
      err_diff <= err_diff_in;
    end
  end

  // Integrator saturation to 48 bits
  assign integ_pos = !acc[ACC_W-1] && (|acc[ACC_W-2:INTEG_W-1]);
  assign integ_neg = acc[ACC_W-1] && !(&acc[ACC_W-2:INTEG_W-1]);

  always_comb begin
    if (integ_pos) begin
      integ_sat = {1'b0, {(INTEG_W-1){1'b1}}};
    end else if (integ_neg) begin
      integ_sat = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      integ_sat = acc[INTEG_W-1:0];
    end
  end

  // Drive: floor to integer, then clamp
  assign u   = acc >>> GAIN_FRACTION_BITS;
  assign top = ACC_W'({SAMPLE_BITS{1'b1}});

  always_comb begin
    drive_wide = u;
    sat_now    = 1'b0;
    if (u < 0) begin
      drive_wide = '0;
      sat_now    = 1'b1;
    end else if (u > top) begin
      drive_wide = top;
      sat_now    = 1'b1;
    end
  end

  // Saturation difference clamped to 32 bits
  assign diff     = (ACC_W+1)'(drive_wide) - (ACC_W+1)'(u);
  assign diff_pos = !diff[ACC_W] && (|diff[ACC_W-1:SDIFF_W-1]);
  assign diff_neg = diff[ACC_W] && !(&diff[ACC_W-1:SDIFF_W-1]);

  always_comb begin
    if (diff_pos) begin
      sdiff_sat = {1'b0, {(SDIFF_W-1){1'b1}}};
    end else if (diff_neg) begin
      sdiff_sat = {1'b1, {(SDIFF_W-1){1'b0}}};
    end else begin
      sdiff_sat = diff[SDIFF_W-1:0];
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      integ    <= '0;
      sdiff    <= '0;
      prev_err <= '0;
    end else if (step_go) begin
      if (ctrl.uw.integ_wr) begin
        integ <= integ_sat;
      end
      if (ctrl.uw.finish) begin
        sdiff    <= sdiff_sat;
        prev_err <= err;
      end
    end
  end

  // Output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go && ctrl.uw.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && ctrl.uw.finish) begin
      drive       <= drive_wide[SAMPLE_BITS-1:0];
      error_value <= err;
      saturated   <= sat_now;
    end
  end

endmodule

>>> design/pid_backcalc_antiwindup_unit.sv
// PID controller with back-calculation anti-windup. Each input transaction
// carries a reference and a measured sample; exactly one output transaction
// follows with the clamped drive (0 .. 2^SAMPLE_BITS-1), the error
// (reference - measured, two's complement) and a flag in tuser that is set
// when the unclamped drive fell outside that range. The integrator (48 bits,
// saturating) adds the error plus gain_backcalc times last tick's clamped
// minus unclamped drive. Gains are signed 24-bit, GAIN_FRACTION_BITS fraction
// bits, written through cfg_we/cfg_index/cfg_data (0 gain_p, 1 gain_i, 2
// gain_d, 3 gain_backcalc) by the user only while the unit is idle; the unit
// does not enforce this. A nine-step microprogram drives a single 24 x 33
// bit multiplier and accumulator, at most one product per step. The next
// sample is taken while a finished result still waits in the output register.
module pid_backcalc_antiwindup_unit
  import pbaw_pkg::*;
#(
  parameter int SAMPLE_BITS        = 12,
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [GAIN_W-1:0]       cfg_data,
  // samples in
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8-1:0]     s_tdata,   // reference, measured
  // results out
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [((2 * SAMPLE_BITS + 1 + 7) / 8) * 8-1:0] m_tdata,   // drive, error_value
  output logic                    m_tuser    // saturated
);

  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((2 * SAMPLE_BITS + 1 + 7) / 8) * 8;

  seq_ctrl_t              ctrl;
  logic                   out_free;
  logic [SAMPLE_BITS-1:0] drive;
  logic [SAMPLE_BITS:0]   error_value;

  pbaw_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  pbaw_datapath #(
    .SAMPLE_BITS        (SAMPLE_BITS),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .reference   (s_tdata[SAMPLE_BITS-1:0]),
    .measured    (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_free    (out_free),
    .drive       (drive),
    .error_value (error_value),
    .saturated   (m_tuser)
  );

  // Sample taken in the microprogram's wait-for-input step
  assign s_tready = (ctrl.uw.waitc == WAIT_IN) && !rst;

  assign m_tdata = OUT_W'({error_value, drive});

endmodule
